// ----- design/lcsmt_pkg.sv -----
// ----------------------------------------------------------------------------
// lcsmt_pkg: shared types and constants of the segment max tree
// Field widths, command codes, sequencer states and the node storage word.
// ----------------------------------------------------------------------------
package lcsmt_pkg;

  localparam int SLOPE_W = 32;
  localparam int ICPT_W  = 48;
  localparam int VALUE_W = 64;
  localparam int LEFT_W  = 10;
  localparam int RIGHT_W = 11;
  localparam int QX_W    = 10;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // One tree node: a stored line and its occupancy flag
  typedef struct packed {
    logic                      valid;
    logic signed [SLOPE_W-1:0] slope;
    logic signed [ICPT_W-1:0]  icpt;
  } node_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WL,
    ST_WR,
    ST_WS,
    ST_DRD,
    ST_DCHK,
    ST_DEV1,
    ST_DEV2,
    ST_DCMP,
    ST_QRD,
    ST_QCHK,
    ST_QW,
    ST_QACC,
    ST_QPUT
  } state_t;

endpackage

// ----- design/lcsmt_node_mem.sv -----
// ----------------------------------------------------------------------------
// lcsmt_node_mem: node line storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lcsmt_node_mem #(
  parameter int ADDR_W = 11
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     waddr,
  input  lcsmt_pkg::node_t      wdata,
  input  logic                  re,
  input  logic [ADDR_W-1:0]     raddr,
  output lcsmt_pkg::node_t      rdata
);

  lcsmt_pkg::node_t mem [0:(1<<ADDR_W)-1];
  lcsmt_pkg::node_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/lcsmt_line_eval.sv -----
// ----------------------------------------------------------------------------
// lcsmt_line_eval: shared line evaluator
// Computes slope*x + intercept in two registered stages (multiply, add).
// ----------------------------------------------------------------------------
module lcsmt_line_eval #(
  parameter int XW = 11
) (
  input  logic                                 clk,
  input  logic signed [lcsmt_pkg::SLOPE_W-1:0] k,
  input  logic signed [lcsmt_pkg::ICPT_W-1:0]  b,
  input  logic        [XW-1:0]                 x,
  output logic signed [lcsmt_pkg::VALUE_W-1:0] y
);

  localparam int PRW = lcsmt_pkg::SLOPE_W + XW + 1;

  logic signed [PRW-1:0]                 prod_r;
  logic signed [lcsmt_pkg::ICPT_W-1:0]   b_r;
  logic signed [lcsmt_pkg::VALUE_W-1:0]  y_r;

  // Multiply stage
  always_ff @(posedge clk) begin
    prod_r <= k * $signed({1'b0, x});
    b_r    <= b;
  end

  // Add stage
  always_ff @(posedge clk) begin
    y_r <= {{(lcsmt_pkg::VALUE_W-PRW){prod_r[PRW-1]}}, prod_r}
         + {{(lcsmt_pkg::VALUE_W-lcsmt_pkg::ICPT_W){b_r[lcsmt_pkg::ICPT_W-1]}}, b_r};
  end

  assign y = y_r;

endmodule

// ----- design/li_chao_segment_max_tree.sv -----
// ----------------------------------------------------------------------------
// li_chao_segment_max_tree: Li Chao tree with segment insert and max query
// Sequencer over a node memory and one shared line evaluator.
// ----------------------------------------------------------------------------
// After reset a clearing pass writes every one of the 2*T node entries (T is
// POSITIONS rounded up to a power of two) with in_tready low. Items are then
// taken one at a time. A query visits one node per tree level and there reads
// it, evaluates it through the two-stage multiply-add unit and accumulates.
// An insert splits its range into at most two nodes per level; each node
// descent reads, runs two evaluations through the shared evaluator and
// compares at each level visited, and an empty or clamped-away range is
// dropped in the cycle that accepts it. The node memory port and the single
// evaluator set this order of steps.
module li_chao_segment_max_tree #(
  parameter int POSITIONS = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // seg_left[9:0], seg_right[20:10], slope[52:21], intercept[100:53],
  // query_x[110:101], zero pad[111]
  input  logic [111:0]  in_tdata,
  // command[0]
  input  logic [0:0]    in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // max_value[63:0]
  output logic [63:0]   out_tdata,
  // found[0]
  output logic [0:0]    out_tuser
);

  localparam int LW = $clog2(POSITIONS);
  localparam int NW = LW + 1;
  localparam int WW = LW + 2;
  localparam int PW = LW + 1;
  localparam int VW = lcsmt_pkg::VALUE_W;

  localparam logic [WW-1:0] LEAF_BASE_W = WW'(1 << LW);
  localparam logic [NW-1:0] LEAF_BASE_N = NW'(1 << LW);

  // Input fields
  logic                                  f_cmd;
  logic [lcsmt_pkg::LEFT_W-1:0]          f_left;
  logic [lcsmt_pkg::RIGHT_W-1:0]         f_right;
  logic signed [lcsmt_pkg::SLOPE_W-1:0]  f_slope;
  logic signed [lcsmt_pkg::ICPT_W-1:0]   f_icpt;
  logic [lcsmt_pkg::QX_W-1:0]            f_qx;

  assign f_cmd   = in_tuser[0];
  assign f_left  = in_tdata[9:0];
  assign f_right = in_tdata[20:10];
  assign f_slope = in_tdata[52:21];
  assign f_icpt  = in_tdata[100:53];
  assign f_qx    = in_tdata[110:101];

  lcsmt_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [NW-1:0]  clr_r, clr_nxt;
  logic [WW-1:0]  wl_r, wl_nxt, wr_r, wr_nxt;
  logic [PW-1:0]  lb_r, lb_nxt, rb_r, rb_nxt, len_r, len_nxt;
  logic [NW-1:0]  dv_r, dv_nxt, qv_r, qv_nxt;
  logic [PW-1:0]  lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt, qx_r, qx_nxt;
  logic signed [lcsmt_pkg::SLOPE_W-1:0] ik_r, ik_nxt, ck_r, ck_nxt;
  logic signed [lcsmt_pkg::ICPT_W-1:0]  ib_r, ib_nxt, cb_r, cb_nxt;
  logic signed [VW-1:0] ys_r, ys_nxt, best_r, best_nxt, out_val_r, out_val_nxt;
  logic fnd_r, fnd_nxt, qvalid_r, qvalid_nxt;
  logic out_valid_r, out_valid_nxt, out_fnd_r, out_fnd_nxt;

  // Memory and evaluator hookup
  logic             mem_we, mem_re;
  logic [NW-1:0]    mem_waddr, mem_raddr;
  lcsmt_pkg::node_t mem_wdata, mem_q;
  logic signed [lcsmt_pkg::SLOPE_W-1:0] ev_k;
  logic signed [lcsmt_pkg::ICPT_W-1:0]  ev_b;
  logic [PW-1:0]                        ev_x;
  logic signed [VW-1:0]                 ev_y;

  lcsmt_node_mem #(.ADDR_W(NW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  lcsmt_line_eval #(.XW(PW)) u_eval (
    .clk (clk),
    .k   (ev_k),
    .b   (ev_b),
    .x   (ev_x),
    .y   (ev_y)
  );

  // Range clamp and checks on the incoming request
  logic [31:0] r_clamp, l_ext, qx_ext;
  always_comb begin
    l_ext   = 32'(f_left);
    qx_ext  = 32'(f_qx);
    r_clamp = (32'(f_right) > 32'(POSITIONS)) ? 32'(POSITIONS) : 32'(f_right);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcsmt_pkg::ST_CLEAR;
      ret_r       <= lcsmt_pkg::ST_IDLE;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    wl_r      <= wl_nxt;
    wr_r      <= wr_nxt;
    lb_r      <= lb_nxt;
    rb_r      <= rb_nxt;
    len_r     <= len_nxt;
    dv_r      <= dv_nxt;
    qv_r      <= qv_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    qx_r      <= qx_nxt;
    ik_r      <= ik_nxt;
    ib_r      <= ib_nxt;
    ck_r      <= ck_nxt;
    cb_r      <= cb_nxt;
    ys_r      <= ys_nxt;
    best_r    <= best_nxt;
    fnd_r     <= fnd_nxt;
    qvalid_r  <= qvalid_nxt;
    out_val_r <= out_val_nxt;
    out_fnd_r <= out_fnd_nxt;
  end

  // Sequencer
  logic [PW:0]   mid_sum;
  logic [WW-1:0] wr_dec;
  logic          swap, stop;
  logic signed [lcsmt_pkg::SLOPE_W-1:0] keep_k, move_k;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    clr_nxt       = clr_r;
    wl_nxt        = wl_r;
    wr_nxt        = wr_r;
    lb_nxt        = lb_r;
    rb_nxt        = rb_r;
    len_nxt       = len_r;
    dv_nxt        = dv_r;
    qv_nxt        = qv_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    qx_nxt        = qx_r;
    ik_nxt        = ik_r;
    ib_nxt        = ib_r;
    ck_nxt        = ck_r;
    cb_nxt        = cb_r;
    ys_nxt        = ys_r;
    best_nxt      = best_r;
    fnd_nxt       = fnd_r;
    qvalid_nxt    = qvalid_r;
    out_val_nxt   = out_val_r;
    out_fnd_nxt   = out_fnd_r;
    out_valid_nxt = out_valid_r && !out_tready;

    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = dv_r;
    mem_wdata = '{valid: 1'b1, slope: ck_r, icpt: cb_r};
    mem_re    = 1'b0;
    mem_raddr = dv_r;
    ev_k      = mem_q.slope;
    ev_b      = mem_q.icpt;
    ev_x      = mid_r;

    mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
    wr_dec  = wr_r - WW'(1);
    swap    = ys_r < ev_y;
    keep_k  = swap ? ck_r : mem_q.slope;
    move_k  = swap ? mem_q.slope : ck_r;
    stop    = (({1'b0, lo_r} + (PW+1)'(1)) == {1'b0, hi_r}) || (mem_q.slope == ck_r);

    case (state_r)
      // Sweep every node entry to empty
      lcsmt_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + NW'(1);
        if (clr_r == {NW{1'b1}}) begin
          state_nxt = lcsmt_pkg::ST_IDLE;
        end
      end

      // Take a request
      lcsmt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (f_cmd == lcsmt_pkg::CMD_INSERT) begin
            ik_nxt  = f_slope;
            ib_nxt  = f_icpt;
            wl_nxt  = LEAF_BASE_W + WW'(l_ext);
            wr_nxt  = LEAF_BASE_W + WW'(r_clamp);
            lb_nxt  = PW'(l_ext);
            rb_nxt  = PW'(r_clamp);
            len_nxt = PW'(1);
            state_nxt = (l_ext < r_clamp) ? lcsmt_pkg::ST_WL : lcsmt_pkg::ST_IDLE;
          end else begin
            fnd_nxt  = 1'b0;
            best_nxt = '0;
            qx_nxt   = PW'(qx_ext);
            qv_nxt   = LEAF_BASE_N + NW'(qx_ext);
            state_nxt = (qx_ext < 32'(POSITIONS)) ? lcsmt_pkg::ST_QRD
                                                  : lcsmt_pkg::ST_QPUT;
          end
        end
      end

      // Left boundary of the canonical split
      lcsmt_pkg::ST_WL: begin
        if (wl_r >= wr_r) begin
          state_nxt = lcsmt_pkg::ST_IDLE;
        end else if (wl_r[0]) begin
          dv_nxt    = wl_r[NW-1:0];
          lo_nxt    = lb_r;
          hi_nxt    = lb_r + len_r;
          ck_nxt    = ik_r;
          cb_nxt    = ib_r;
          wl_nxt    = wl_r + WW'(1);
          lb_nxt    = lb_r + len_r;
          ret_nxt   = lcsmt_pkg::ST_WR;
          state_nxt = lcsmt_pkg::ST_DRD;
        end else begin
          state_nxt = lcsmt_pkg::ST_WR;
        end
      end

      // Right boundary of the canonical split
      lcsmt_pkg::ST_WR: begin
        if (wr_r[0]) begin
          wr_nxt    = wr_dec;
          dv_nxt    = wr_dec[NW-1:0];
          lo_nxt    = rb_r - len_r;
          hi_nxt    = rb_r;
          ck_nxt    = ik_r;
          cb_nxt    = ib_r;
          rb_nxt    = rb_r - len_r;
          ret_nxt   = lcsmt_pkg::ST_WS;
          state_nxt = lcsmt_pkg::ST_DRD;
        end else begin
          state_nxt = lcsmt_pkg::ST_WS;
        end
      end

      // Move up one level
      lcsmt_pkg::ST_WS: begin
        wl_nxt    = wl_r >> 1;
        wr_nxt    = wr_r >> 1;
        len_nxt   = len_r << 1;
        state_nxt = lcsmt_pkg::ST_WL;
      end

      // Descent: read the node and find its midpoint
      lcsmt_pkg::ST_DRD: begin
        mem_re    = 1'b1;
        mid_nxt   = mid_sum[PW:1];
        state_nxt = lcsmt_pkg::ST_DCHK;
      end

      // Store into an empty node, else evaluate the stored line
      lcsmt_pkg::ST_DCHK: begin
        if (!mem_q.valid) begin
          mem_we    = 1'b1;
          state_nxt = ret_r;
        end else begin
          state_nxt = lcsmt_pkg::ST_DEV1;
        end
      end

      // Evaluate the carried line
      lcsmt_pkg::ST_DEV1: begin
        ev_k      = ck_r;
        ev_b      = cb_r;
        state_nxt = lcsmt_pkg::ST_DEV2;
      end

      // Capture the stored line's value
      lcsmt_pkg::ST_DEV2: begin
        ys_nxt    = ev_y;
        state_nxt = lcsmt_pkg::ST_DCMP;
      end

      // Keep the winner, push the loser toward its side
      lcsmt_pkg::ST_DCMP: begin
        if (swap) begin
          mem_we = 1'b1;
          ck_nxt = mem_q.slope;
          cb_nxt = mem_q.icpt;
        end
        if (stop) begin
          state_nxt = ret_r;
        end else if (keep_k > move_k) begin
          dv_nxt    = dv_r << 1;
          hi_nxt    = mid_r;
          state_nxt = lcsmt_pkg::ST_DRD;
        end else begin
          dv_nxt    = (dv_r << 1) | NW'(1);
          lo_nxt    = mid_r;
          state_nxt = lcsmt_pkg::ST_DRD;
        end
      end

      // Query: read the node on the path
      lcsmt_pkg::ST_QRD: begin
        mem_re    = 1'b1;
        mem_raddr = qv_r;
        state_nxt = lcsmt_pkg::ST_QCHK;
      end

      lcsmt_pkg::ST_QCHK: begin
        ev_x       = qx_r;
        qvalid_nxt = mem_q.valid;
        state_nxt  = lcsmt_pkg::ST_QW;
      end

      lcsmt_pkg::ST_QW: begin
        state_nxt = lcsmt_pkg::ST_QACC;
      end

      // Fold the node value into the running maximum
      lcsmt_pkg::ST_QACC: begin
        if (qvalid_r) begin
          fnd_nxt = 1'b1;
          if (!fnd_r || (ev_y > best_r)) begin
            best_nxt = ev_y;
          end
        end
        qv_nxt    = qv_r >> 1;
        state_nxt = ((qv_r >> 1) == '0) ? lcsmt_pkg::ST_QPUT : lcsmt_pkg::ST_QRD;
      end

      // Hand the result to the output register once it is free
      lcsmt_pkg::ST_QPUT: begin
        if (!out_valid_r || out_tready) begin
          out_val_nxt   = fnd_r ? best_r : '0;
          out_fnd_nxt   = fnd_r;
          out_valid_nxt = 1'b1;
          state_nxt     = lcsmt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lcsmt_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_val_r;
  assign out_tuser[0] = out_fnd_r;

`ifndef ASSERT_OFF
  // Descent never addresses the unused node zero
  a_dv_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lcsmt_pkg::ST_DCHK || state_r == lcsmt_pkg::ST_DCMP) |-> (dv_r != '0))
    else $error("descent at node zero");

  // Node range stays non-empty during descent
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lcsmt_pkg::ST_DCMP) |-> (lo_r < hi_r))
    else $error("empty node range in descent");

  // A result without a covering line carries zero
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0))
    else $error("nonzero value without found");

  // No request is taken during the clearing pass
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lcsmt_pkg::ST_CLEAR) |-> !in_tready)
    else $error("ready during clear");
`endif

endmodule

// ----- tb/tb_li_chao_segment_max_tree.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_li_chao_segment_max_tree: stream-level check of the segment max tree
// A queue of pending requests feeds a clocked driver. A behavioral line tree
// predicts every query answer, and a clocked monitor compares each answer
// field by field. Phases vary sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_li_chao_segment_max_tree;

  localparam int NPOS   = 1024;
  localparam int LEAVES = 1024;
  localparam int LIMIT  = 3000000;

  localparam int LEFT_W  = lcsmt_pkg::LEFT_W;
  localparam int RIGHT_W = lcsmt_pkg::RIGHT_W;
  localparam int SLOPE_W = lcsmt_pkg::SLOPE_W;
  localparam int ICPT_W  = lcsmt_pkg::ICPT_W;
  localparam int QX_W    = lcsmt_pkg::QX_W;
  localparam int VALUE_W = lcsmt_pkg::VALUE_W;

  typedef struct packed {
    logic                      cmd;
    logic [LEFT_W-1:0]         left;
    logic [RIGHT_W-1:0]        right;
    logic signed [SLOPE_W-1:0] slope;
    logic signed [ICPT_W-1:0]  icpt;
    logic [QX_W-1:0]           qx;
  } request_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      found;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [111:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [0:0] out_tuser;

  li_chao_segment_max_tree #(.POSITIONS(NPOS)) dut (.*);

  // Predictor state: one line per tree node
  logic                      tree_valid [2*LEAVES];
  logic signed [SLOPE_W-1:0] tree_slope [2*LEAVES];
  logic signed [ICPT_W-1:0]  tree_icpt  [2*LEAVES];

  request_t pending_reqs [$];
  answer_t  expected_answers [$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_send = 1'b0;

  initial forever #2 clk = ~clk;

  function automatic logic signed [63:0] line_value(logic signed [SLOPE_W-1:0] k,
      logic signed [ICPT_W-1:0] b, int x);
    logic signed [63:0] kx;
    kx = 64'(k) * 64'(x);
    return kx + 64'(b);
  endfunction

  // Push a line down from one canonical node
  task automatic push_line(int v, int lo, int hi, logic signed [SLOPE_W-1:0] k,
      logic signed [ICPT_W-1:0] b);
    int mid;
    logic signed [SLOPE_W-1:0] tk;
    logic signed [ICPT_W-1:0] tb;
    forever begin
      if (!tree_valid[v]) begin
        tree_valid[v] = 1'b1;
        tree_slope[v] = k;
        tree_icpt[v] = b;
        return;
      end
      mid = (lo + hi) / 2;
      if (line_value(tree_slope[v], tree_icpt[v], mid) < line_value(k, b, mid)) begin
        tk = tree_slope[v];
        tb = tree_icpt[v];
        tree_slope[v] = k;
        tree_icpt[v] = b;
        k = tk;
        b = tb;
      end
      if (lo + 1 == hi || tree_slope[v] == k) return;
      if (tree_slope[v] > k) begin
        v = 2 * v;
        hi = mid;
      end else begin
        v = 2 * v + 1;
        lo = mid;
      end
    end
  endtask

  // Apply one accepted request; queries yield an answer
  task automatic predict(request_t rq);
    int l, r, lb, rb, len, x, v;
    answer_t a;
    logic signed [63:0] y;
    if (rq.cmd == lcsmt_pkg::CMD_INSERT) begin
      l = rq.left;
      r = rq.right;
      if (r > NPOS) r = NPOS;
      lb = l;
      rb = r;
      len = 1;
      l += LEAVES;
      r += LEAVES;
      while (l < r) begin
        if (l % 2 == 1) begin
          push_line(l, lb, lb + len, rq.slope, rq.icpt);
          l++;
          lb += len;
        end
        if (r % 2 == 1) begin
          r--;
          push_line(r, rb - len, rb, rq.slope, rq.icpt);
          rb -= len;
        end
        l = l / 2;
        r = r / 2;
        len *= 2;
      end
    end else begin
      a = '0;
      x = rq.qx;
      if (x < NPOS) begin
        for (v = x + LEAVES; v > 0; v = v / 2) begin
          if (tree_valid[v]) begin
            y = line_value(tree_slope[v], tree_icpt[v], x);
            if (!a.found || y > a.value) a.value = y;
            a.found = 1'b1;
          end
        end
      end
      expected_answers.push_back(a);
    end
  endtask

  // Drive requests from the pending queue
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      // Retire the accepted request
      if (in_tvalid && in_tready) begin
        predict(pending_reqs[0]);
        pending_reqs.delete(0);
      end
      // Hold a waiting request, else offer the next one
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle) begin
          in_tvalid <= 1'b1;
          in_tuser  <= pending_reqs[0].cmd;
          in_tdata  <= {1'b0, pending_reqs[0].qx, pending_reqs[0].icpt,
                        pending_reqs[0].slope, pending_reqs[0].right,
                        pending_reqs[0].left};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Compare each accepted answer with the oldest prediction
  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected answer value=%0d found=%0d", $signed(out_tdata), out_tuser);
        errors++;
      end else begin
        e = expected_answers[0];
        expected_answers.delete(0);
        if (out_tdata !== e.value) begin
          $error("max_value expected %0d actual %0d", e.value, $signed(out_tdata));
          errors++;
        end
        if (out_tuser[0] !== e.found) begin
          $error("found expected %0d actual %0d", e.found, out_tuser[0]);
          errors++;
        end
      end
    end
  end

  // Stop a run that hangs
  always @(posedge clk) begin
    if (cycles >= LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic request_t rand_insert(bit wide);
    request_t rq;
    int span;
    rq = '0;
    rq.cmd = lcsmt_pkg::CMD_INSERT;
    rq.left = LEFT_W'($urandom_range(1023));
    span = wide ? $urandom_range(1100) : $urandom_range(40);
    rq.right = ($urandom_range(15) == 0) ? RIGHT_W'($urandom) : RIGHT_W'(rq.left + span);
    rq.slope = $urandom_range(3) == 0 ? $signed(32'($urandom))
                                      : SLOPE_W'($signed($urandom_range(2000)) - 1000);
    rq.icpt = ICPT_W'({$urandom, $urandom});
    if (rq.icpt[47:46] == 2'b01 || rq.icpt[47:46] == 2'b10) rq.icpt[46] = rq.icpt[47];
    rq.qx = QX_W'($urandom);
    return rq;
  endfunction

  function automatic request_t rand_query();
    request_t rq;
    rq = '0;
    rq = rand_insert(1'b1);
    rq.cmd = lcsmt_pkg::CMD_QUERY;
    return rq;
  endfunction

  task automatic drain(bit long_wait);
    while (pending_reqs.size() > 0 || expected_answers.size() > 0) @(posedge clk);
    if (long_wait) repeat (600) @(posedge clk);
  endtask

  initial begin
    request_t rq;
    int ph, i;
    for (i = 0; i < 2*LEAVES; i++) begin
      tree_valid[i] = 1'b0;
      tree_slope[i] = '0;
      tree_icpt[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty tree, extremes of fields, clamped and empty ranges
    rq = '0; rq.cmd = lcsmt_pkg::CMD_QUERY; rq.qx = 0; pending_reqs.push_back(rq);
    rq.qx = 1023; pending_reqs.push_back(rq);
    rq = '0; rq.cmd = lcsmt_pkg::CMD_INSERT; rq.left = 5; rq.right = 5; rq.slope = 7;
    rq.icpt = 9; pending_reqs.push_back(rq);
    rq.left = 10; rq.right = 3; pending_reqs.push_back(rq);
    rq.left = 1023; rq.right = 2047; pending_reqs.push_back(rq);
    rq.left = 0; rq.right = 1024; rq.slope = 32'h7fffffff;
    rq.icpt = 48'h7fffffffffff; pending_reqs.push_back(rq);
    rq.slope = 32'h80000000; rq.icpt = 48'h800000000000; pending_reqs.push_back(rq);
    rq.right = 512; rq.slope = 32'h7fffffff; rq.icpt = 0; pending_reqs.push_back(rq);
    rq.left = 100; rq.right = 300; rq.slope = -5; rq.icpt = 48'h7fffffffffff;
    pending_reqs.push_back(rq);
    rq.slope = -5; rq.icpt = 12345; pending_reqs.push_back(rq);
    rq = '0; rq.cmd = lcsmt_pkg::CMD_QUERY; rq.left = 10'h3ff; rq.right = 11'h7ff;
    rq.slope = '1; rq.icpt = '1;
    for (i = 0; i < QX_W; i++) begin
      rq.qx = QX_W'(1 << i); pending_reqs.push_back(rq);
    end
    rq.qx = 1023; pending_reqs.push_back(rq);
    rq.qx = 0; pending_reqs.push_back(rq);
    drain(1'b0);

    // Random phases under different idling
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 84; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 84; end
        default: begin send_idle = 7; recv_stall = 7; end
      endcase
      for (i = 0; i < 160; i++)
        pending_reqs.push_back($urandom_range(1) ? rand_insert($urandom_range(9) == 0)
                                                 : rand_query());
      if (ph == 1) begin
        while (pending_reqs.size() > 80) @(posedge clk);
        hold_send = 1'b1;
        while (expected_answers.size() > 0) @(posedge clk);
        hold_send = 1'b0;
      end
      drain(1'b0);
    end

    drain(1'b1);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
